@@ src/sssp_pkg.sv @@
package sssp_pkg;

  // Sizing defaults
  localparam int MaxNodesDef   = 1024;
  localparam int MaxEdgesDef   = 16384;
  localparam int WeightBitsDef = 8;

  // Fixed field widths
  localparam int NodeBits  = 10;
  localparam int CountBits = 11;
  localparam int DistBits  = 31;

  // Distance sentinel and saturation cap
  localparam logic [DistBits-1:0] Unreached = 31'h7FFF_FFFF;
  localparam logic [DistBits-1:0] DistCap   = 31'h7FFF_FFFE;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_RUN   = 2'd2,
    OP_QUERY = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOT_RUN  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_SOURCE = 2'd0,
    REG_COUNT  = 2'd1,
    REG_SPARE2 = 2'd2,
    REG_SPARE3 = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QUERY,
    S_INIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MARK,
    S_EDGE_RD,
    S_EDGE_CHK,
    S_NODE_CHK
  } state_t;

  // Node memory word
  typedef struct packed {
    logic                done;
    logic [DistBits-1:0] path_len;
  } node_word_t;

endpackage

@@ src/single_source_shortest_paths.sv @@
// Dijkstra shortest paths over an undirected graph held in an edge memory.
// Clear, add edge and every rejected command finish in S_IDLE: busy stays
// low and the result strobe (done) comes on the next cycle. A query of a
// valid node passes through S_QUERY for the read of the distance memory. A
// run first sweeps all MAX_NODES entries of the distance memory (S_INIT),
// then for each reached node scans the live nodes (S_SCAN_RD, S_SCAN_CHK),
// marks the node (S_MARK) and walks every loaded edge (S_EDGE_RD,
// S_EDGE_CHK), plus S_NODE_CHK for each edge from the marked node to another
// live node, since all node reads and writes share the one distance memory
// port pair. A last scan that finds no node ends the run. The receiver
// cannot stall: each result is shown for exactly one cycle with done high.
module single_source_shortest_paths #(
  parameter int MAX_NODES   = sssp_pkg::MaxNodesDef,
  parameter int MAX_EDGES   = sssp_pkg::MaxEdgesDef,
  parameter int WEIGHT_BITS = sssp_pkg::WeightBitsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [9:0]  node_a,
  input  logic [9:0]  node_b,
  input  logic [7:0]  edge_weight,
  output logic        done,
  output logic [1:0]  status,
  output logic [30:0] distance,
  output logic        reachable,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int NB  = sssp_pkg::NodeBits;
  localparam int DB  = sssp_pkg::DistBits;
  localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW0 = $clog2(MAX_NODES + 1);
  localparam int CW  = (CW0 > sssp_pkg::CountBits) ? CW0 : sssp_pkg::CountBits;
  localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EDW = 2 * NB + WEIGHT_BITS;
  localparam int NDW = DB + 1;

  // configuration registers
  logic [NB-1:0]                  source_node;
  logic [sssp_pkg::CountBits-1:0] node_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_node <= '0;
      node_count  <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      case (sssp_pkg::reg_index_t'(cfg_index))
        sssp_pkg::REG_SOURCE: source_node <= cfg_data[NB-1:0];
        sssp_pkg::REG_COUNT:  node_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  // live node count, clipped to the memory size
  logic [CW-1:0] live;
  assign live = (CW'(node_count) > CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count);

  sssp_pkg::state_t state, state_next;
  logic [ECW-1:0]   edges_loaded;
  logic             results_valid;
  logic [CW-1:0]    idx;
  logic [ECW-1:0]   eidx;
  logic [DB-1:0]    best;
  logic [NW-1:0]    u_node;
  logic             found;
  logic [NW-1:0]    v_node;
  logic [DB-1:0]    cand;

  assign busy = (state != sssp_pkg::S_IDLE);

  logic accept;
  sssp_pkg::opcode_t op;
  assign accept = start && !busy;
  assign op     = sssp_pkg::opcode_t'(opcode);

  logic a_ok, b_ok, src_ok;
  assign a_ok   = CW'(node_a) < live;
  assign b_ok   = CW'(node_b) < live;
  assign src_ok = CW'(source_node) < live;

  // memories
  logic                 edge_we;
  logic [EW-1:0]        edge_waddr, edge_raddr;
  logic [EDW-1:0]       edge_wdata, edge_rdata;
  logic                 node_we;
  logic [NW-1:0]        node_waddr, node_raddr;
  sssp_pkg::node_word_t node_wdata, node_rdata;
  logic [NDW-1:0]       node_rbits;

  sssp_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  sssp_ram #(.WIDTH(NDW), .DEPTH(MAX_NODES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rbits)
  );
  assign node_rdata = sssp_pkg::node_word_t'(node_rbits);

  // edge read fields
  logic [NB-1:0]          e_a, e_b;
  logic [WEIGHT_BITS-1:0] e_w;
  assign e_a = edge_rdata[EDW-1 -: NB];
  assign e_b = edge_rdata[WEIGHT_BITS +: NB];
  assign e_w = edge_rdata[WEIGHT_BITS-1:0];

  // edge decision: relax the far end if this edge touches u
  logic e_in, relax_b, relax_a, relax_any;
  logic [NW-1:0] v_sel;
  assign e_in      = (CW'(e_a) < live) && (CW'(e_b) < live);
  assign relax_b   = e_in && (CW'(e_a) == CW'(u_node)) && (CW'(e_b) != CW'(u_node));
  assign relax_a   = e_in && (CW'(e_b) == CW'(u_node)) && (CW'(e_a) != CW'(u_node));
  assign relax_any = relax_b || relax_a;
  assign v_sel     = relax_b ? NW'(e_b) : NW'(e_a);

  // candidate distance, saturated
  logic [DB:0] sum;
  assign sum  = {1'b0, best} + (DB+1)'(e_w);

  // scan step
  logic scan_take, scan_last, edge_last;
  assign scan_take = !node_rdata.done && (node_rdata.path_len < best);
  assign scan_last = (idx + 1'b1) == live;
  assign edge_last = (eidx + 1'b1) == edges_loaded;

  logic relax_wr;
  assign relax_wr = !node_rdata.done && (node_rdata.path_len > cand);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sssp_pkg::S_IDLE: begin
        if (accept && op == sssp_pkg::OP_RUN && src_ok) begin
          state_next = sssp_pkg::S_INIT;
        end else if (accept && op == sssp_pkg::OP_QUERY && results_valid && a_ok) begin
          state_next = sssp_pkg::S_QUERY;
        end
      end
      sssp_pkg::S_QUERY: state_next = sssp_pkg::S_IDLE;
      sssp_pkg::S_INIT: begin
        if (idx == CW'(MAX_NODES - 1)) begin
          state_next = sssp_pkg::S_SCAN_RD;
        end
      end
      sssp_pkg::S_SCAN_RD: state_next = sssp_pkg::S_SCAN_CHK;
      sssp_pkg::S_SCAN_CHK: begin
        if (!scan_last) begin
          state_next = sssp_pkg::S_SCAN_RD;
        end else if (found || scan_take) begin
          state_next = sssp_pkg::S_MARK;
        end else begin
          state_next = sssp_pkg::S_IDLE;
        end
      end
      sssp_pkg::S_MARK: begin
        state_next = (edges_loaded == '0) ? sssp_pkg::S_SCAN_RD : sssp_pkg::S_EDGE_RD;
      end
      sssp_pkg::S_EDGE_RD: state_next = sssp_pkg::S_EDGE_CHK;
      sssp_pkg::S_EDGE_CHK: begin
        if (relax_any) begin
          state_next = sssp_pkg::S_NODE_CHK;
        end else begin
          state_next = edge_last ? sssp_pkg::S_SCAN_RD : sssp_pkg::S_EDGE_RD;
        end
      end
      sssp_pkg::S_NODE_CHK: begin
        state_next = edge_last ? sssp_pkg::S_SCAN_RD : sssp_pkg::S_EDGE_RD;
      end
      default: state_next = sssp_pkg::S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    edge_we    = 1'b0;
    edge_waddr = EW'(edges_loaded);
    edge_wdata = {node_a, node_b, WEIGHT_BITS'(edge_weight)};
    edge_raddr = EW'(eidx);
    node_we    = 1'b0;
    node_waddr = NW'(idx);
    node_wdata = '{done: 1'b0, path_len: sssp_pkg::Unreached};
    node_raddr = NW'(node_a);
    case (state)
      sssp_pkg::S_IDLE: begin
        edge_we = accept && op == sssp_pkg::OP_ADD && a_ok && b_ok
                  && (edges_loaded != ECW'(MAX_EDGES));
      end
      sssp_pkg::S_INIT: begin
        node_we = 1'b1;
        if (NW'(idx) == NW'(source_node)) begin
          node_wdata.path_len = '0;
        end
      end
      sssp_pkg::S_SCAN_RD: node_raddr = NW'(idx);
      sssp_pkg::S_MARK: begin
        node_we    = 1'b1;
        node_waddr = u_node;
        node_wdata = '{done: 1'b1, path_len: best};
      end
      sssp_pkg::S_EDGE_CHK: node_raddr = v_sel;
      sssp_pkg::S_NODE_CHK: begin
        node_we    = relax_wr;
        node_waddr = v_node;
        node_wdata = '{done: 1'b0, path_len: cand};
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sssp_pkg::S_IDLE;
      edges_loaded  <= '0;
      results_valid <= 1'b0;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (accept) begin
        done <= !((op == sssp_pkg::OP_RUN && src_ok)
                  || (op == sssp_pkg::OP_QUERY && results_valid && a_ok));
        case (op)
          sssp_pkg::OP_CLEAR: begin
            edges_loaded  <= '0;
            results_valid <= 1'b0;
          end
          sssp_pkg::OP_ADD: begin
            if (edge_we) begin
              edges_loaded  <= edges_loaded + 1'b1;
              results_valid <= 1'b0;
            end
          end
          sssp_pkg::OP_RUN: begin
            results_valid <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state == sssp_pkg::S_QUERY) begin
        done <= 1'b1;
      end
      if (state == sssp_pkg::S_SCAN_CHK && state_next == sssp_pkg::S_IDLE) begin
        done          <= 1'b1;
        results_valid <= 1'b1;
      end
    end
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    case (state)
      sssp_pkg::S_IDLE: begin
        idx <= '0;
        if (accept) begin
          distance  <= '0;
          reachable <= 1'b0;
          status    <= sssp_pkg::ST_OK;
          case (op)
            sssp_pkg::OP_ADD: begin
              if (!(a_ok && b_ok)) begin
                status <= sssp_pkg::ST_RANGE;
              end else if (edges_loaded == ECW'(MAX_EDGES)) begin
                status <= sssp_pkg::ST_FULL;
              end
            end
            sssp_pkg::OP_RUN: begin
              if (!src_ok) begin
                status <= sssp_pkg::ST_RANGE;
              end
            end
            sssp_pkg::OP_QUERY: begin
              if (!results_valid) begin
                status <= sssp_pkg::ST_NOT_RUN;
              end else if (!a_ok) begin
                status <= sssp_pkg::ST_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      sssp_pkg::S_QUERY: begin
        distance  <= node_rdata.path_len;
        reachable <= node_rdata.path_len != sssp_pkg::Unreached;
      end
      sssp_pkg::S_INIT: begin
        idx   <= (idx == CW'(MAX_NODES - 1)) ? '0 : idx + 1'b1;
        best  <= sssp_pkg::Unreached;
        found <= 1'b0;
      end
      sssp_pkg::S_SCAN_CHK: begin
        if (scan_take) begin
          best   <= node_rdata.path_len;
          u_node <= NW'(idx);
          found  <= 1'b1;
        end
        idx <= scan_last ? '0 : idx + 1'b1;
      end
      sssp_pkg::S_MARK: begin
        eidx <= '0;
      end
      sssp_pkg::S_EDGE_CHK: begin
        v_node <= v_sel;
        cand   <= sum[DB] ? sssp_pkg::DistCap
                  : ((sum[DB-1:0] > sssp_pkg::DistCap) ? sssp_pkg::DistCap : sum[DB-1:0]);
        if (!relax_any) begin
          eidx <= eidx + 1'b1;
        end
        if (!relax_any && edge_last) begin
          best  <= sssp_pkg::Unreached;
          found <= 1'b0;
        end
      end
      sssp_pkg::S_NODE_CHK: begin
        eidx <= eidx + 1'b1;
        if (edge_last) begin
          best  <= sssp_pkg::Unreached;
          found <= 1'b0;
        end
      end
      default: ;
    endcase
    if (state == sssp_pkg::S_MARK && edges_loaded == '0) begin
      best  <= sssp_pkg::Unreached;
      found <= 1'b0;
    end
  end

  // checks
  a_query_done: assert property (@(posedge clk) disable iff (rst)
    state == sssp_pkg::S_QUERY |=> done)
    else $error("query read produced no result");

  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == sssp_pkg::S_SCAN_RD || state == sssp_pkg::S_SCAN_CHK) |-> !node_we)
    else $error("distance memory written during scan");

  a_edges_bound: assert property (@(posedge clk) disable iff (rst)
    edges_loaded <= ECW'(MAX_EDGES))
    else $error("edge count past table size");

  a_reach_dist: assert property (@(posedge clk) disable iff (rst)
    (done && reachable) |-> (distance != sssp_pkg::Unreached && status == sssp_pkg::ST_OK))
    else $error("reachable node reports sentinel");

  a_busy_no_done: assert property (@(posedge clk) disable iff (rst)
    (busy && state != sssp_pkg::S_QUERY) |=> !done || !busy)
    else $error("result strobe while still running");

endmodule

@@ src/sssp_ram.sv @@
module sssp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
